@@ src/plas_pkg.sv @@
// ----------------------------------------------------------------------------
// plas_pkg
// Shared types, constants and elaboration-time table functions for the
// launch angle solver.
// ----------------------------------------------------------------------------
package plas_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int SQRT_STEPS       = 64;
  localparam int ANGLE_W          = 24;

  localparam logic [63:0] PI_OVER_4_Q62   = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9836E4E44152A;

  // shared item data after the radicand stage
  typedef struct packed {
    logic        ok;
    logic        den_neg;
    logic [63:0] a;
    logic [63:0] bm;
  } plas_meta_t;

  typedef struct packed {
    plas_meta_t   meta;
    logic [127:0] radicand;
  } plas_rad_t;

  typedef struct packed {
    plas_meta_t  meta;
    logic [63:0] root;
  } plas_root_t;

  typedef struct packed {
    logic               ok;
    logic signed [63:0] x;
    logic signed [63:0] y;
  } plas_vec_t;

  // restoring long division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-idx) in quarter turns, Q62 (truncated series, as specified)
  function automatic logic [63:0] atan_entry(input int idx);
    logic [63:0]  rad;
    logic [63:0]  term;
    logic [127:0] prod;
    int           k;
    int           e;
    rad = '0;
    k   = 0;
    if (idx == 0) begin
      rad = PI_OVER_4_Q62;
    end else begin
      e = 62 - idx;
      while (e >= 0) begin
        term = udiv64(64'd1 << e, 64'(2 * k + 1));
        if (k[0]) begin
          rad = rad - term;
        end else begin
          rad = rad + term;
        end
        k = k + 1;
        e = 62 - idx * (2 * k + 1);
      end
    end
    prod = {64'd0, rad} * {64'd0, TWO_OVER_PI_Q64};
    return prod[127:64];
  endfunction

endpackage

@@ src/plas_if.sv @@
// ----------------------------------------------------------------------------
// plas_in_if / plas_out_if
// Valid/ready channels for query items and solved angle pairs.
// ----------------------------------------------------------------------------
interface plas_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gravity_q16;
  logic signed [31:0] launch_speed_q16;
  logic signed [31:0] horizontal_distance_q16;
  logic signed [31:0] target_height_q16;

  modport source (
    output valid, gravity_q16, launch_speed_q16, horizontal_distance_q16, target_height_q16,
    input  ready
  );
  modport sink (
    input  valid, gravity_q16, launch_speed_q16, horizontal_distance_q16, target_height_q16,
    output ready
  );
endinterface

interface plas_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] steep_angle_deg_q16;
  logic signed [23:0] flat_angle_deg_q16;
  logic               solution_valid;

  modport source (
    output valid, steep_angle_deg_q16, flat_angle_deg_q16, solution_valid,
    input  ready
  );
  modport sink (
    input  valid, steep_angle_deg_q16, flat_angle_deg_q16, solution_valid,
    output ready
  );
endinterface

@@ src/plas_radicand.sv @@
// ----------------------------------------------------------------------------
// plas_radicand
// Six-stage front end: magnitudes, products, 128-bit radicand and checks.
// ----------------------------------------------------------------------------
module plas_radicand (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  in_g,
  input  logic signed [31:0]  in_v,
  input  logic signed [31:0]  in_d,
  input  logic signed [31:0]  in_h,
  output logic                out_valid,
  output plas_pkg::plas_rad_t out_data
);
  import plas_pkg::*;

  logic [5:0] v_r;

  // stage 1: magnitudes and sign relations
  logic [31:0] gm_r, vm_r, dm_r, hm_r;
  logic        zero_r, gh_diff_r, den_neg_r;
  // stage 2: first products
  logic [63:0] a_r, bm_r, gh_r;
  logic        zero2_r, gh_diff2_r, den_neg2_r;
  // stage 3: partial products
  logic [63:0] a_ll_r, a_lh_r, a_hh_r, b_ll_r, b_lh_r, b_hh_r;
  logic [63:0] t_ll_r, t_lh_r, t_hl_r, t_hh_r;
  logic [63:0] a3_r, bm3_r;
  logic        zero3_r, gh_diff3_r, den_neg3_r;
  // stage 4: full products
  logic [127:0] pos_r, negp_r, t2_r;
  logic [63:0]  a4_r, bm4_r;
  logic         zero4_r, gh_diff4_r, den_neg4_r;
  // stage 5: signed term folded in
  logic [127:0] pos5_r, negp5_r;
  logic [63:0]  a5_r, bm5_r;
  logic         zero5_r, den_neg5_r;
  // stage 6: output
  plas_rad_t    out_r;

  logic [31:0]  gm_nxt, vm_nxt, dm_nxt, hm_nxt;
  logic [127:0] t_sum;
  logic [128:0] diff;

  assign gm_nxt = in_g[31] ? 32'(-in_g) : in_g;
  assign vm_nxt = in_v[31] ? 32'(-in_v) : in_v;
  assign dm_nxt = in_d[31] ? 32'(-in_d) : in_d;
  assign hm_nxt = in_h[31] ? 32'(-in_h) : in_h;

  assign t_sum = {t_hh_r, t_ll_r} + {32'd0, t_lh_r, 32'd0} + {32'd0, t_hl_r, 32'd0};
  assign diff  = {1'b0, pos5_r} - {1'b0, negp5_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gm_r      <= gm_nxt;
      vm_r      <= vm_nxt;
      dm_r      <= dm_nxt;
      hm_r      <= hm_nxt;
      zero_r    <= (gm_nxt == '0) || (vm_nxt == '0) || (dm_nxt == '0);
      gh_diff_r <= in_g[31] ^ in_h[31];
      den_neg_r <= in_g[31] ^ in_d[31];

      a_r        <= 64'(vm_r) * 64'(vm_r);
      bm_r       <= 64'(gm_r) * 64'(dm_r);
      gh_r       <= 64'(gm_r) * 64'(hm_r);
      zero2_r    <= zero_r;
      gh_diff2_r <= gh_diff_r;
      den_neg2_r <= den_neg_r;

      a_ll_r     <= 64'(a_r[31:0])   * 64'(a_r[31:0]);
      a_lh_r     <= 64'(a_r[31:0])   * 64'(a_r[63:32]);
      a_hh_r     <= 64'(a_r[63:32])  * 64'(a_r[63:32]);
      b_ll_r     <= 64'(bm_r[31:0])  * 64'(bm_r[31:0]);
      b_lh_r     <= 64'(bm_r[31:0])  * 64'(bm_r[63:32]);
      b_hh_r     <= 64'(bm_r[63:32]) * 64'(bm_r[63:32]);
      t_ll_r     <= 64'(gh_r[31:0])  * 64'(a_r[31:0]);
      t_lh_r     <= 64'(gh_r[31:0])  * 64'(a_r[63:32]);
      t_hl_r     <= 64'(gh_r[63:32]) * 64'(a_r[31:0]);
      t_hh_r     <= 64'(gh_r[63:32]) * 64'(a_r[63:32]);
      a3_r       <= a_r;
      bm3_r      <= bm_r;
      zero3_r    <= zero2_r;
      gh_diff3_r <= gh_diff2_r;
      den_neg3_r <= den_neg2_r;

      // cross term of a square counts twice
      pos_r      <= {a_hh_r, a_ll_r} + {31'd0, a_lh_r, 33'd0};
      negp_r     <= {b_hh_r, b_ll_r} + {31'd0, b_lh_r, 33'd0};
      t2_r       <= {t_sum[126:0], 1'b0};
      a4_r       <= a3_r;
      bm4_r      <= bm3_r;
      zero4_r    <= zero3_r;
      gh_diff4_r <= gh_diff3_r;
      den_neg4_r <= den_neg3_r;

      pos5_r     <= gh_diff4_r ? pos_r + t2_r : pos_r;
      negp5_r    <= gh_diff4_r ? negp_r : negp_r + t2_r;
      a5_r       <= a4_r;
      bm5_r      <= bm4_r;
      zero5_r    <= zero4_r;
      den_neg5_r <= den_neg4_r;

      out_r.radicand     <= diff[127:0];
      out_r.meta.ok      <= !zero5_r && !diff[128];
      out_r.meta.den_neg <= den_neg5_r;
      out_r.meta.a       <= a5_r;
      out_r.meta.bm      <= bm5_r;
    end
  end

  assign out_valid = v_r[5];
  assign out_data  = out_r;

endmodule

@@ src/plas_sqrt.sv @@
// ----------------------------------------------------------------------------
// plas_sqrt
// Floor square root of a 128-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module plas_sqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  plas_pkg::plas_rad_t  in_data,
  output logic                 out_valid,
  output plas_pkg::plas_root_t out_data
);
  import plas_pkg::*;

  logic                 valid_r [SQRT_STEPS];
  logic [65:0]          rem_r   [SQRT_STEPS];
  logic [63:0]          root_r  [SQRT_STEPS];
  logic [127:0]         x_r     [SQRT_STEPS];
  plas_meta_t           meta_r  [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    logic        v_in;
    logic [65:0] rem_in;
    logic [63:0] root_in;
    logic [127:0] x_in;
    plas_meta_t  meta_in;
    logic [67:0] wide;
    logic [67:0] trial;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = in_data.radicand;
      assign meta_in = in_data.meta;
    end else begin : g_next
      assign v_in    = valid_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign x_in    = x_r[i-1];
      assign meta_in = meta_r[i-1];
    end

    assign wide  = {rem_in, x_in[127:126]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= {x_in[125:0], 2'b00};
        meta_r[i] <= meta_in;
        if (wide >= trial) begin
          rem_r[i]  <= 66'(wide - trial);
          root_r[i] <= {root_in[62:0], 1'b1};
        end else begin
          rem_r[i]  <= wide[65:0];
          root_r[i] <= {root_in[62:0], 1'b0};
        end
      end
    end
  end

  assign out_valid     = valid_r[SQRT_STEPS-1];
  assign out_data.meta = meta_r[SQRT_STEPS-1];
  assign out_data.root = root_r[SQRT_STEPS-1];

endmodule

@@ src/plas_prep.sv @@
// ----------------------------------------------------------------------------
// plas_prep
// Two stages: numerators for both roots, then range reduction into the
// CORDIC start vectors.
// ----------------------------------------------------------------------------
module plas_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  plas_pkg::plas_root_t in_data,
  output logic                 out_valid,
  output plas_pkg::plas_vec_t  out_steep,
  output plas_pkg::plas_vec_t  out_flat
);
  import plas_pkg::*;

  logic [1:0]  v_r;
  logic [63:0] num1_r, num2_r, bm_r;
  logic        neg1_r, neg2_r, ok_r;
  plas_vec_t   steep_r, flat_r;

  logic        n2neg;
  logic [63:0] a_v, s_v;

  assign a_v   = in_data.meta.a;
  assign s_v   = in_data.root;
  assign n2neg = a_v < s_v;

  // shift so both magnitudes sit below 2^60
  function automatic logic [2:0] norm_shift(input logic [63:0] v);
    logic [2:0] n;
    n = 3'd0;
    if (v[63]) begin
      n = 3'd4;
    end else if (v[62]) begin
      n = 3'd3;
    end else if (v[61]) begin
      n = 3'd2;
    end else if (v[60]) begin
      n = 3'd1;
    end
    return n;
  endfunction

  function automatic plas_vec_t make_vec(input logic [63:0] num, input logic [63:0] den,
                                         input logic neg, input logic ok);
    plas_vec_t   r;
    logic [2:0]  n;
    logic [63:0] ys;
    n    = norm_shift(num | den);
    ys   = num >> n;
    r.ok = ok;
    r.x  = signed'(den >> n);
    r.y  = neg ? -signed'(ys) : signed'(ys);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1_r  <= a_v + s_v;
      num2_r  <= n2neg ? s_v - a_v : a_v - s_v;
      neg1_r  <= in_data.meta.den_neg;
      neg2_r  <= n2neg ^ in_data.meta.den_neg;
      bm_r    <= in_data.meta.bm;
      ok_r    <= in_data.meta.ok;
      steep_r <= make_vec(num1_r, bm_r, neg1_r, ok_r);
      flat_r  <= make_vec(num2_r, bm_r, neg2_r, ok_r);
    end
  end

  assign out_valid = v_r[1];
  assign out_steep = steep_r;
  assign out_flat  = flat_r;

endmodule

@@ src/plas_cordic.sv @@
// ----------------------------------------------------------------------------
// plas_cordic
// One vectoring CORDIC lane, one rotation per stage, followed by two stages
// that scale quarter turns to degrees, round and saturate.
// ----------------------------------------------------------------------------
module plas_cordic #(
  parameter int FRAC_BITS    = plas_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = plas_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  plas_pkg::plas_vec_t               in_vec,
  output logic                              out_valid,
  output logic                              out_ok,
  output logic signed [plas_pkg::ANGLE_W-1:0] out_angle
);
  import plas_pkg::*;

  localparam logic [63:0] ANGLE_LIMIT = 64'(90) << FRAC_BITS;
  localparam logic [63:0] ROUND_HALF  = 64'd1 << (55 - FRAC_BITS);
  localparam int          DEG_SHIFT   = 56 - FRAC_BITS;

  logic               valid_r [CORDIC_STEPS];
  logic               ok_r    [CORDIC_STEPS];
  logic signed [63:0] x_r     [CORDIC_STEPS];
  logic signed [63:0] y_r     [CORDIC_STEPS];
  logic signed [63:0] z_r     [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [63:0] ATAN_I = signed'(atan_entry(i));
    logic               v_in, ok_in;
    logic signed [63:0] x_in, y_in, z_in, xs, ys;
    logic signed [63:0] x_nxt, y_nxt, z_nxt;

    if (i == 0) begin : g_first
      assign v_in  = in_valid;
      assign ok_in = in_vec.ok;
      assign x_in  = in_vec.x;
      assign y_in  = in_vec.y;
      assign z_in  = '0;
    end else begin : g_next
      assign v_in  = valid_r[i-1];
      assign ok_in = ok_r[i-1];
      assign x_in  = x_r[i-1];
      assign y_in  = y_r[i-1];
      assign z_in  = z_r[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;

    always_comb begin
      if (!y_in[63]) begin
        x_nxt = x_in + ys;
        y_nxt = y_in - xs;
        z_nxt = z_in + ATAN_I;
      end else begin
        x_nxt = x_in - ys;
        y_nxt = y_in + xs;
        z_nxt = z_in - ATAN_I;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ok_r[i] <= ok_in;
        x_r[i]  <= x_nxt;
        y_r[i]  <= y_nxt;
        z_r[i]  <= z_nxt;
      end
    end
  end

  // degree scaling
  logic [1:0]  dv_r;
  logic [63:0] deg_r;
  logic        zneg_r, dok_r, ok2_r;
  logic signed [ANGLE_W-1:0] angle_r;

  logic signed [63:0] z_end;
  logic [63:0]        mag, q6, deg_rnd, deg_sat, deg_signed;

  assign z_end      = z_r[CORDIC_STEPS-1];
  assign mag        = z_end[63] ? 64'(-z_end) : 64'(z_end);
  assign q6         = mag >> 6;
  assign deg_rnd    = (deg_r + ROUND_HALF) >> DEG_SHIFT;
  assign deg_sat    = (deg_rnd > ANGLE_LIMIT) ? ANGLE_LIMIT : deg_rnd;
  assign deg_signed = zneg_r ? 64'd0 - deg_sat : deg_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[0], valid_r[CORDIC_STEPS-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // times 90 as shift-add
      deg_r   <= (q6 << 6) + (q6 << 4) + (q6 << 3) + (q6 << 1);
      zneg_r  <= z_end[63];
      dok_r   <= ok_r[CORDIC_STEPS-1];
      angle_r <= dok_r ? signed'(deg_signed[ANGLE_W-1:0]) : '0;
      ok2_r   <= dok_r;
    end
  end

  assign out_valid = dv_r[1];
  assign out_ok    = ok2_r;
  assign out_angle = angle_r;

endmodule

@@ src/projectile_launch_angle_solver.sv @@
// ----------------------------------------------------------------------------
// projectile_launch_angle_solver
// Both launch angles that hit (d, h) for gravity g and speed v, in degrees.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    gravity, launch speed, distance, height (Q16.16)
//  out_ch    out  valid/ready    steep angle, flat angle (24b), solution_valid
//
// One item per cycle while out_ch is not stalled. The pipe is 6 radicand stages,
// 64 square-root stages (one root bit each), 2 setup stages, one stage per
// CORDIC rotation, 2 degree-scaling stages. The last scaling register is the
// output register. Reset clears all stage valid bits; payload is not reset.
// The whole pipe advances together: a stalled output holds every stage and
// lowers in_ch.ready, so no transfer is lost or repeated.
//
module projectile_launch_angle_solver #(
  parameter int FRAC_BITS    = plas_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = plas_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  plas_in_if.sink    in_ch,
  plas_out_if.source out_ch
);
  import plas_pkg::*;

  logic       en;          // pipeline advance
  logic       rad_valid, root_valid, prep_valid;
  logic       steep_valid, flat_valid, steep_ok, flat_ok;
  plas_rad_t  rad_data;
  plas_root_t root_data;
  plas_vec_t  steep_vec, flat_vec;
  logic signed [ANGLE_W-1:0] steep_angle, flat_angle;

  // advance whenever the output register is empty or being drained
  assign en          = !steep_valid || out_ch.ready;
  assign in_ch.ready = en;

  // g*d, v^2 and radicand v^4 - g(g d^2 + 2 h v^2)
  plas_radicand u_radicand (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_g      (in_ch.gravity_q16),
    .in_v      (in_ch.launch_speed_q16),
    .in_d      (in_ch.horizontal_distance_q16),
    .in_h      (in_ch.target_height_q16),
    .out_valid (rad_valid),
    .out_data  (rad_data)
  );

  plas_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rad_valid),
    .in_data   (rad_data),
    .out_valid (root_valid),
    .out_data  (root_data)
  );

  // v^2 +/- root over g*d, scaled into CORDIC range
  plas_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (root_valid),
    .in_data   (root_data),
    .out_valid (prep_valid),
    .out_steep (steep_vec),
    .out_flat  (flat_vec)
  );

  // two CORDIC lanes in lockstep
  plas_cordic #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic_steep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (prep_valid),
    .in_vec    (steep_vec),
    .out_valid (steep_valid),
    .out_ok    (steep_ok),
    .out_angle (steep_angle)
  );

  plas_cordic #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic_flat (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (prep_valid),
    .in_vec    (flat_vec),
    .out_valid (flat_valid),
    .out_ok    (flat_ok),
    .out_angle (flat_angle)
  );

  // lanes share valid and ok; both are carried so each lane is self-contained
  assign out_ch.valid               = steep_valid && flat_valid;
  assign out_ch.steep_angle_deg_q16 = steep_angle;
  assign out_ch.flat_angle_deg_q16  = flat_angle;
  assign out_ch.solution_valid      = steep_ok && flat_ok;

endmodule

@@ test/projectile_launch_angle_solver_test.sv @@
// ----------------------------------------------------------------------------
// projectile_launch_angle_solver_test
// Drives launch queries through the solver with random gaps on both sides
// and checks every angle pair against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module projectile_launch_angle_solver_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB         = plas_pkg::FRAC_BITS_DEF;
  localparam int STEPS      = plas_pkg::CORDIC_STEPS_DEF;
  localparam int LATENCY    = 74 + STEPS;
  localparam int RAND_ITEMS = 450;
  localparam int MAX_GAP    = 12;
  localparam int CYCLE_CAP  = 200000;
  localparam logic [63:0] ANGLE_SAT = 64'd5898240;  // 90 degrees in Q16.16

  typedef struct {
    logic signed [31:0] g;
    logic signed [31:0] v;
    logic signed [31:0] d;
    logic signed [31:0] h;
  } query_t;

  typedef struct {
    logic signed [23:0] steep;
    logic signed [23:0] flat;
    logic               ok;
  } angle_pair_t;

  // Predicts angle pairs for accepted queries and matches them in order.
  class angle_book;
    angle_pair_t pending[$];
    logic [63:0] atan_q62[STEPS];
    int          errors;

    function new();
      logic [63:0]  rad;
      logic [63:0]  term;
      logic [127:0] prod;
      int           k;
      int           e;
      errors = 0;
      for (int i = 0; i < STEPS; i++) begin
        if (i == 0) begin
          rad = plas_pkg::PI_OVER_4_Q62;
        end else begin
          rad = '0;
          k   = 0;
          e   = 62 - i;
          while (e >= 0) begin
            term = (64'd1 << e) / 64'(2 * k + 1);
            if (k % 2 == 1) rad = rad - term;
            else rad = rad + term;
            k = k + 1;
            e = 62 - i * (2 * k + 1);
          end
        end
        // radians to quarter turns
        prod = {64'd0, rad} * {64'd0, plas_pkg::TWO_OVER_PI_Q64};
        atan_q62[i] = prod[127:64];
      end
    endfunction

    function logic [63:0] root_floor(logic [127:0] x);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] sq;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c  = r | (64'd1 << b);
        sq = {64'd0, c} * {64'd0, c};
        if (!(x < sq)) r = c;
      end
      return r;
    endfunction

    // atan(+/- ym / xm) in degrees, vectoring CORDIC
    function logic [23:0] cordic_deg(logic [63:0] ym, bit neg, logic [63:0] xm);
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
      logic signed [63:0] xs;
      logic signed [63:0] ys;
      logic [63:0]        m;
      logic [63:0]        deg;
      while ((xm | ym) >= (64'd1 << 60)) begin
        xm = xm >> 1;
        ym = ym >> 1;
      end
      x = xm;
      y = neg ? -$signed(ym) : $signed(ym);
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + $signed(atan_q62[i]);
        end else begin
          x = x - ys; y = y + xs; z = z - $signed(atan_q62[i]);
        end
      end
      m   = (z < 0) ? 64'(-z) : 64'(z);
      deg = (m >> 6) * 64'd90;
      deg = (deg + (64'd1 << (55 - FB))) >> (56 - FB);
      if (deg > ANGLE_SAT) deg = ANGLE_SAT;
      if (z < 0) deg = -deg;
      return deg[23:0];
    endfunction

    function logic [63:0] mag32(logic [31:0] r);
      return {32'd0, r[31] ? (~r + 32'd1) : r};
    endfunction

    function void note_query(query_t q);
      angle_pair_t  res;
      logic [63:0]  gm, vm, dm, hm, a, bm, s, n2;
      logic [127:0] pos, negp, t2;
      bit           den_neg, n2neg;
      res = '{steep: '0, flat: '0, ok: 1'b0};
      gm = mag32(q.g);
      vm = mag32(q.v);
      dm = mag32(q.d);
      hm = mag32(q.h);
      if (gm != 0 && vm != 0 && dm != 0) begin
        a    = vm * vm;
        bm   = gm * dm;
        pos  = {64'd0, a} * {64'd0, a};
        negp = {64'd0, bm} * {64'd0, bm};
        t2   = ({64'd0, gm * hm} * {64'd0, a}) << 1;
        if (q.g[31] != q.h[31]) pos = pos + t2;
        else negp = negp + t2;
        // negative radicand: target out of reach
        if (!(pos < negp)) begin
          s       = root_floor(pos - negp);
          den_neg = q.g[31] != q.d[31];
          n2neg   = a < s;
          n2      = n2neg ? s - a : a - s;
          res.steep = cordic_deg(a + s, den_neg, bm);
          res.flat  = cordic_deg(n2, n2neg != den_neg, bm);
          res.ok    = 1'b1;
        end
      end
      pending.push_back(res);
    endfunction

    function void check_angles(angle_pair_t got);
      angle_pair_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: steep %0d flat %0d ok %0d",
               got.steep, got.flat, got.ok);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.steep !== want.steep) begin
        $error("steep_angle_deg_q16: expected %0d, actual %0d", want.steep, got.steep);
        errors++;
      end
      if (got.flat !== want.flat) begin
        $error("flat_angle_deg_q16: expected %0d, actual %0d", want.flat, got.flat);
        errors++;
      end
      if (got.ok !== want.ok) begin
        $error("solution_valid: expected %0d, actual %0d", want.ok, got.ok);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  bit   sending_done;

  plas_in_if  in_ch ();
  plas_out_if out_ch ();

  projectile_launch_angle_solver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  angle_book book = new();

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Random query: mostly plausible ballistics, plus raw noise, tiny
  // integers (zero operands, exact roots) and corner values.
  function automatic logic signed [31:0] pick_sign(logic [31:0] m);
    return $urandom_range(0, 1) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] corner_val();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sd1;
      3: return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    int     mode;
    mode = $urandom_range(0, 9);
    if (mode <= 1) begin
      q = '{g: $urandom, v: $urandom, d: $urandom, h: $urandom};
    end else if (mode <= 7) begin
      q.g = pick_sign($urandom_range(1, 40 << 16));
      q.v = pick_sign($urandom_range(1, 200 << 16));
      q.d = pick_sign($urandom_range(1, 4000 << 16));
      q.h = pick_sign($urandom_range(0, 2000 << 16));
    end else if (mode == 8) begin
      q.g = $signed($urandom_range(0, 16)) - 8;
      q.v = $signed($urandom_range(0, 16)) - 8;
      q.d = $signed($urandom_range(0, 16)) - 8;
      q.h = $signed($urandom_range(0, 16)) - 8;
    end else begin
      q = '{g: corner_val(), v: corner_val(), d: corner_val(), h: corner_val()};
    end
    return q;
  endfunction

  // Long runs without gaps now and then, otherwise an idle gap of random length.
  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // One query transfer; valid stays high across back-to-back items.
  task automatic send_query(query_t q, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid                   <= 1'b1;
    in_ch.gravity_q16             <= q.g;
    in_ch.launch_speed_q16        <= q.v;
    in_ch.horizontal_distance_q16 <= q.d;
    in_ch.target_height_q16       <= q.h;
    do @(posedge clk); while (!in_ch.ready);
    book.note_query(q);
  endtask

  query_t directed[$];

  initial begin
    bit burst;
    in_ch.valid                   <= 1'b0;
    in_ch.gravity_q16             <= '0;
    in_ch.launch_speed_q16        <= '0;
    in_ch.horizontal_distance_q16 <= '0;
    in_ch.target_height_q16       <= '0;
    rst_n                         <= 1'b0;
    sending_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero gravity, zero speed, zero distance
    directed.push_back('{g: 0, v: 5 << 16, d: 10 << 16, h: 0});
    directed.push_back('{g: -(9 << 16), v: 0, d: 10 << 16, h: 0});
    directed.push_back('{g: -(9 << 16), v: 5 << 16, d: 0, h: 1 << 16});
    directed.push_back('{g: 0, v: 0, d: 0, h: 0});
    // textbook shots, each sign of g, d and h
    directed.push_back('{g: -(642253), v: 30 << 16, d: 50 << 16, h: 0});
    directed.push_back('{g: 642253, v: 30 << 16, d: -(50 << 16), h: 5 << 16});
    directed.push_back('{g: -(642253), v: -(30 << 16), d: -(50 << 16), h: -(20 << 16)});
    directed.push_back('{g: 642253, v: 30 << 16, d: 50 << 16, h: -(7 << 16)});
    // far out of reach, then a target far below
    directed.push_back('{g: -(642253), v: 1 << 16, d: 1000 << 16, h: 0});
    directed.push_back('{g: 642253, v: 2 << 16, d: 10 << 16, h: -(900 << 16)});
    // numerator of the flat angle exactly zero
    directed.push_back('{g: 2, v: 1, d: 1, h: -1});
    directed.push_back('{g: -2, v: -1, d: 1, h: 1});
    // field extremes
    directed.push_back('{g: 32'sh7FFFFFFF, v: 32'sh7FFFFFFF, d: 32'sh7FFFFFFF, h: 32'sh7FFFFFFF});
    directed.push_back('{g: 32'sh80000000, v: 32'sh80000000, d: 32'sh80000000, h: 32'sh80000000});
    directed.push_back('{g: 32'sh80000000, v: 32'sh7FFFFFFF, d: 1, h: 32'sh80000000});
    directed.push_back('{g: 1, v: 32'sh7FFFFFFF, d: 1, h: 0});
    directed.push_back('{g: 1, v: 1, d: 32'sh7FFFFFFF, h: 32'sh7FFFFFFF});
    directed.push_back('{g: -1, v: 32'sh80000000, d: 32'sh80000000, h: 32'sh7FFFFFFF});
    directed.push_back('{g: 1, v: 1, d: 1, h: 0});
    directed.push_back('{g: -1, v: -1, d: -1, h: -1});

    foreach (directed[i]) send_query(directed[i], draw_gap(i < 6));
    burst = 1'b0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      send_query(random_query(), draw_gap(burst));
    end
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Result side: random stalls, with occasional stretches of none.
  initial begin
    angle_pair_t got;
    bit          eager;
    int          gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    eager = 1'b0;
    forever begin
      if ($urandom_range(0, 30) == 0) eager = !eager;
      gap = eager ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.steep = out_ch.steep_angle_deg_q16;
      got.flat  = out_ch.flat_angle_deg_q16;
      got.ok    = out_ch.solution_valid;
      book.check_angles(got);
    end
  end

  // Watchdog and verdict.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("status: fail");
        $finish;
      end
      if (sending_done && book.pending.size() == 0) begin
        // drain window: anything extra would show up as an unexpected transfer
        repeat (2 * LATENCY) @(posedge clk);
        if (book.errors == 0 && book.pending.size() == 0) begin
          $display("status: pass");
        end else begin
          $display("status: fail");
        end
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
src/plas_pkg.sv
src/plas_if.sv
src/plas_radicand.sv
src/plas_sqrt.sv
src/plas_prep.sv
src/plas_cordic.sv
src/projectile_launch_angle_solver.sv
test/projectile_launch_angle_solver_test.sv
